@@ rtl/xlb_pkg.sv @@
// shared constants, command and status types for the xor linear basis block
package xlb_pkg;

    localparam int TOP_BIT    = 30;
    localparam int ROW_COUNT  = TOP_BIT + 1;
    localparam int VEC_W      = TOP_BIT + 1;
    localparam int IDX_W      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int RANK_W     = $clog2(ROW_COUNT + 1);
    localparam int IN_VEC_W   = 31;
    localparam int MAX_XOR_W  = 31;
    localparam int RANK_OUT_W = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef logic [VEC_W-1:0]  t_vec;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [RANK_W-1:0] t_rank;

    typedef struct packed {
        logic load;
        logic clear;
        logic step;
        logic commit;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_sts;

endpackage

@@ rtl/xlb_in_if.sv @@
// input channel: valid, ready and one item
interface xlb_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [xlb_pkg::IN_VEC_W-1:0] vector_value;

    modport source (output valid, output action, output vector_value, input ready);
    modport sink (input valid, input action, input vector_value, output ready);
endinterface

@@ rtl/xlb_out_if.sv @@
// output channel: valid, ready and one result
interface xlb_out_if;
    logic                           valid;
    logic                           ready;
    logic [xlb_pkg::MAX_XOR_W-1:0]  max_xor;
    logic                           added_row;
    logic [xlb_pkg::RANK_OUT_W-1:0] rank_now;

    modport source (output valid, output max_xor, output added_row, output rank_now,
                    input ready);
    modport sink (input valid, input max_xor, input added_row, input rank_now,
                  output ready);
endinterface

@@ rtl/xlb_ctrl.sv @@
// sequencing state machine and handshake control for the basis datapath
module xlb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_action,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output xlb_pkg::t_cmd o_cmd,
    input  xlb_pkg::t_sts i_sts
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WALK   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_xfer;
    logic   w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    o_cmd.load = 1'b1;
                    if (i_in_action == xlb_pkg::ACT_CLEAR) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_DONE;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_sts.last) |=> (r_state == S_UPDATE))
        else $error("walk did not end in update");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_out_valid && r_state == S_IDLE))
        else $error("emitted result not presented");

endmodule

@@ rtl/xlb_dpath.sv @@
// basis rows, reduction walk, row update and result registers
module xlb_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  xlb_pkg::t_cmd                  i_cmd,
    input  logic [xlb_pkg::IN_VEC_W-1:0]   i_vector_value,
    output xlb_pkg::t_sts                  o_sts,
    output logic [xlb_pkg::MAX_XOR_W-1:0]  o_max_xor,
    output logic                           o_added_row,
    output logic [xlb_pkg::RANK_OUT_W-1:0] o_rank_now
);

    xlb_pkg::t_vec  r_rows [xlb_pkg::ROW_COUNT];
    xlb_pkg::t_vec  n_rows [xlb_pkg::ROW_COUNT];
    xlb_pkg::t_vec  r_vec, n_vec;
    xlb_pkg::t_vec  r_acc, n_acc;
    xlb_pkg::t_rank r_rank, n_rank;
    xlb_pkg::t_idx  r_j, n_j;
    xlb_pkg::t_idx  r_pivot, n_pivot;
    logic           r_found, n_found;
    xlb_pkg::t_vec  w_row_j;
    logic           w_col_par;

    logic [xlb_pkg::MAX_XOR_W-1:0]  r_out_max;
    logic                           r_out_added;
    logic [xlb_pkg::RANK_OUT_W-1:0] r_out_rank;

    assign w_row_j   = r_rows[r_j];
    assign o_sts.last = (r_j == '0);

    always_comb begin
        w_col_par = 1'b0;
        for (int k = 0; k < xlb_pkg::ROW_COUNT; k++) begin
            w_col_par = w_col_par ^ r_rows[k][r_pivot];
        end
    end

    always_comb begin
        n_vec   = r_vec;
        n_j     = r_j;
        n_pivot = r_pivot;
        n_found = r_found;
        n_acc   = r_acc;
        n_rank  = r_rank;
        for (int k = 0; k < xlb_pkg::ROW_COUNT; k++) begin
            n_rows[k] = r_rows[k];
        end

        if (i_cmd.load) begin
            n_vec   = xlb_pkg::VEC_W'(i_vector_value);
            n_j     = xlb_pkg::IDX_W'(xlb_pkg::TOP_BIT);
            n_found = 1'b0;
        end

        if (i_cmd.clear) begin
            n_acc  = '0;
            n_rank = '0;
            for (int k = 0; k < xlb_pkg::ROW_COUNT; k++) begin
                n_rows[k] = '0;
            end
        end

        if (i_cmd.step) begin
            if (r_vec[r_j]) begin
                if (w_row_j != '0) begin
                    n_vec = r_vec ^ w_row_j;
                end else if (!r_found) begin
                    n_found = 1'b1;
                    n_pivot = r_j;
                end
            end
            if (r_j != '0) begin
                n_j = r_j - xlb_pkg::IDX_W'(1);
            end
        end

        if (i_cmd.commit && r_found) begin
            // higher rows holding the new pivot bit absorb the new row
            for (int k = 0; k < xlb_pkg::ROW_COUNT; k++) begin
                if (r_rows[k][r_pivot]) begin
                    n_rows[k] = r_rows[k] ^ r_vec;
                end
            end
            n_rows[r_pivot] = r_vec;
            n_acc  = w_col_par ? r_acc : (r_acc ^ r_vec);
            n_rank = r_rank + xlb_pkg::RANK_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_rank  <= '0;
            r_found <= 1'b0;
            for (int k = 0; k < xlb_pkg::ROW_COUNT; k++) begin
                r_rows[k] <= '0;
            end
        end else begin
            r_acc   <= n_acc;
            r_rank  <= n_rank;
            r_found <= n_found;
            for (int k = 0; k < xlb_pkg::ROW_COUNT; k++) begin
                r_rows[k] <= n_rows[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec   <= n_vec;
        r_j     <= n_j;
        r_pivot <= n_pivot;
        if (i_cmd.emit) begin
            r_out_max   <= xlb_pkg::MAX_XOR_W'(r_acc);
            r_out_added <= r_found;
            r_out_rank  <= xlb_pkg::RANK_OUT_W'(r_rank);
        end
    end

    assign o_max_xor   = r_out_max;
    assign o_added_row = r_out_added;
    assign o_rank_now  = r_out_rank;

    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rank <= xlb_pkg::RANK_W'(xlb_pkg::ROW_COUNT))
        else $error("rank beyond row count");

endmodule

@@ rtl/xor_linear_basis_top.sv @@
// top level of the xor linear basis: controller, datapath and channel wiring
// an insert is walked and committed before its result is registered; a clear skips both
// the reduction walk visits one basis row per cycle, top bit down, then an update state
// no new item is taken until the previous one has moved into the output register
// a finished result waits in an output register while the next item is taken
// synchronous active-low reset empties the basis and drops any pending result
module xor_linear_basis_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xlb_in_if.sink    i_in,
    xlb_out_if.source o_out
);

    xlb_pkg::t_cmd w_cmd;
    xlb_pkg::t_sts w_sts;

    xlb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    xlb_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_vector_value (i_in.vector_value),
        .o_sts          (w_sts),
        .o_max_xor      (o_out.max_xor),
        .o_added_row    (o_out.added_row),
        .o_rank_now     (o_out.rank_now)
    );

endmodule
